/* sv/tep_pkg.sv */
package tep_pkg;
   localparam int unsigned MaxArgsDefault = 16;
   localparam int unsigned MaxIntermedDefault = 2;
   localparam int unsigned ArgWidth = 17;

   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_CTRL = 2'd1;
   localparam logic [1:0] KIND_ESC  = 2'd2;
   localparam logic [1:0] KIND_CSI  = 2'd3;

   localparam logic [7:0] BYTE_ESC = 8'h1b;
   localparam logic [7:0] BYTE_CSI = 8'h9b;
   localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
   localparam logic [7:0] BYTE_SEMI = 8'h3b;
   localparam logic [7:0] BYTE_QUEST = 8'h3f;
   localparam logic [31:0] REPLACEMENT = 32'h0000_fffd;

   // parser modes, one-hot
   typedef enum logic [2:0] {
      MODE_GROUND = 3'b001,
      MODE_ESCAPE = 3'b010,
      MODE_CSI    = 3'b100
   } mode_type;

   // result bundle
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [7:0]  csi_command;
      logic [15:0] csi_intermediates;
      logic [1:0]  csi_intermed_count;
      logic        csi_private;
      logic        csi_overflow;
      logic        last;
   } result_type;
endpackage

/* sv/tep_arg_ram.sv */
module tep_arg_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* sv/terminal_escape_utf8_parser.sv */
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_in_byte
// rsp     | out       | rsp_valid, rsp_stall, rsp_kind .. rsp_last
// csr     | in        | csr_wr_en, csr_wr_data (utf8_mode)
//
// A byte with two results (U+FFFD, then the byte's own result) stalls input until
// the second is emitted. A CSI digit stalls input for its argument read-modify-write.
// A non-private CSI final byte emits one result per argument (memory read, then emit).
// Arguments live in a one-port-read synchronous memory, validity in a mask
// of flip-flops so entering a CSI clears all arguments at once.
// Reset is synchronous; the output register holds its result under rsp_stall.
module terminal_escape_utf8_parser #(
   parameter int unsigned MAX_ARGS = tep_pkg::MaxArgsDefault,
   parameter int unsigned MAX_INTERMED = tep_pkg::MaxIntermedDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic signed [31:0] rsp_value,
   output logic [7:0]  rsp_csi_command,
   output logic [15:0] rsp_csi_intermediates,
   output logic [1:0]  rsp_csi_intermed_count,
   output logic        rsp_csi_private,
   output logic        rsp_csi_overflow,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import tep_pkg::*;

   localparam int unsigned AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam int unsigned IW = $clog2(MAX_INTERMED + 1);
   localparam int unsigned IS = 8 * MAX_INTERMED;

   // configuration and parser state
   logic utf8_mode_ff;
   mode_type mode_ff, mode_in;
   logic [2:0] left_ff, left_in;
   logic [30:0] accum_ff, accum_in;
   logic first_ff, first_in, inter_ff, inter_in;
   logic [IS-1:0] istore_ff, istore_in;
   logic [IW-1:0] icount_ff, icount_in;
   logic [AW-1:0] aidx_ff, aidx_in;
   logic [MAX_ARGS-1:0] avalid_ff, avalid_in;
   logic priv_ff, priv_in, ovf_ff, ovf_in, excess_ff, excess_in;

   // pending second result and argument emission
   logic pend_ff, pend_in;
   result_type pend_res_ff, pend_res_in;
   logic emit_ff, emit_in;
   logic rd_wait_ff, rd_wait_in;
   logic [AW-1:0] eidx_ff, eidx_in;
   logic [7:0] cmd_ff, cmd_in;

   // argument read-modify-write
   logic [AW-1:0] rd_addr;
   logic [ArgWidth-1:0] rd_data;
   logic wr_en;
   logic [ArgWidth-1:0] wr_data;
   logic digit_pend_ff, digit_pend_in;
   logic [3:0] digit_ff, digit_in;
   logic [AW-1:0] daddr_ff, daddr_in;

   logic out_v_ff, out_v_in;
   result_type out_ff, out_in;

   logic out_free, busy, take;
   logic [7:0] c;
   result_type r0, r1;
   logic n0, n1;
   logic [20:0] prod;
   logic [ArgWidth-1:0] cur;

   tep_arg_ram #(.DEPTH(1 << AW), .WIDTH(ArgWidth)) u_args (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(daddr_ff),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free = !out_v_ff || !rsp_stall;
   assign busy = pend_ff || emit_ff || digit_pend_ff;
   assign req_stall = busy || !out_free;
   assign take = req_valid && !req_stall;
   assign c = req_in_byte;

   // digit accumulate on read data of last cycle
   always_comb begin
      cur = avalid_ff[daddr_ff] ? rd_data : '0;
      prod = 21'(cur) * 21'd10 + 21'(digit_ff);
      wr_en = digit_pend_ff;
      wr_data = (prod > 21'd65535) ? ArgWidth'(65535) : ArgWidth'(prod);
   end

   // read address: digit target or emission index
   assign rd_addr = (emit_ff) ? eidx_ff : aidx_ff;

   function automatic result_type mk(input logic [1:0] k, input logic [31:0] v);
      result_type r;
      r = '0;
      r.kind = k;
      r.value = v;
      return r;
   endfunction

   always_comb begin
      mode_in = mode_ff; left_in = left_ff; accum_in = accum_ff;
      first_in = first_ff; inter_in = inter_ff; istore_in = istore_ff;
      icount_in = icount_ff; aidx_in = aidx_ff; avalid_in = avalid_ff;
      priv_in = priv_ff; ovf_in = ovf_ff; excess_in = excess_ff;
      pend_in = pend_ff; pend_res_in = pend_res_ff;
      emit_in = emit_ff; rd_wait_in = 1'b0; eidx_in = eidx_ff; cmd_in = cmd_ff;
      digit_pend_in = 1'b0; digit_in = digit_ff; daddr_in = daddr_ff;
      out_v_in = out_v_ff && rsp_stall; out_in = out_ff;
      r0 = '0; r1 = '0; n0 = 1'b0; n1 = 1'b0;

      if (digit_pend_ff) begin
         avalid_in[daddr_ff] = 1'b1;
         if (prod > 21'd65535) ovf_in = 1'b1;
      end

      if (out_free && pend_ff) begin
         // second result of a two-result byte
         out_v_in = 1'b1; out_in = pend_res_ff; pend_in = 1'b0;
      end else if (emit_ff) begin
         if (rd_wait_ff) begin
            rd_wait_in = 1'b0;
         end else if (out_free) begin
            out_v_in = 1'b1;
            out_in = '0;
            out_in.kind = KIND_CSI;
            out_in.value = avalid_ff[eidx_ff] ? 32'(rd_data) : 32'hffff_ffff;
            out_in.csi_command = cmd_ff;
            out_in.csi_intermediates = 16'(istore_ff);
            out_in.csi_intermed_count = 2'(icount_ff);
            out_in.csi_overflow = ovf_ff;
            out_in.last = (eidx_ff == aidx_ff);
            if (eidx_ff == aidx_ff) begin
               emit_in = 1'b0;
            end else begin
               eidx_in = eidx_ff + 1'b1;
               rd_wait_in = 1'b1;
            end
         end
      end else if (take) begin
         unique case (mode_ff)
            MODE_ESCAPE: begin
               if (c == BYTE_LBRACKET) begin
                  mode_in = MODE_CSI; first_in = 1'b1; inter_in = 1'b1;
                  istore_in = '0; icount_in = '0; aidx_in = '0; avalid_in = '0;
                  priv_in = 1'b0; ovf_in = 1'b0; excess_in = 1'b0;
               end else begin
                  r0 = mk(KIND_ESC, {24'd0, c}); n0 = 1'b1; mode_in = MODE_GROUND;
               end
            end
            MODE_CSI: begin
               if (c >= 8'h40 && c <= 8'h7f) begin
                  mode_in = MODE_GROUND;
                  if (priv_ff) begin
                     r0 = mk(KIND_CSI, 32'hffff_ffff); r0.csi_command = c;
                     r0.csi_private = 1'b1; n0 = 1'b1;
                  end else begin
                     emit_in = 1'b1; rd_wait_in = 1'b1; eidx_in = '0; cmd_in = c;
                  end
               end else if (first_ff && c >= 8'h3c && c <= 8'h3e) begin
                  first_in = 1'b0; priv_in = 1'b1;
               end else if (!priv_ff) begin
                  first_in = 1'b0;
                  if (inter_ff && (c[7:4] == 4'h2 || c == BYTE_QUEST)) begin
                     if (icount_ff < IW'(MAX_INTERMED)) begin
                        istore_in = {istore_ff[IS-9:0], c} ;
                        icount_in = icount_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end else begin
                     inter_in = 1'b0;
                     if (c >= 8'h30 && c <= 8'h39) begin
                        if (!excess_ff) begin
                           digit_pend_in = 1'b1; digit_in = c[3:0]; daddr_in = aidx_ff;
                        end
                     end else if (c == BYTE_SEMI) begin
                        if (32'(aidx_ff) + 1 < MAX_ARGS) aidx_in = aidx_ff + 1'b1;
                        else begin excess_in = 1'b1; ovf_in = 1'b1; end
                     end
                  end
               end
            end
            default: begin
               mode_in = MODE_GROUND;
               if (c < 8'h20 || (!utf8_mode_ff && c >= 8'h80 && c < 8'ha0)) begin
                  left_in = '0;
                  if (c == BYTE_ESC) mode_in = MODE_ESCAPE;
                  else if (c == BYTE_CSI) begin
                     mode_in = MODE_CSI; first_in = 1'b1; inter_in = 1'b1;
                     istore_in = '0; icount_in = '0; aidx_in = '0; avalid_in = '0;
                     priv_in = 1'b0; ovf_in = 1'b0; excess_in = 1'b0;
                  end else begin r0 = mk(KIND_CTRL, {24'd0, c}); n0 = 1'b1; end
               end else if (!utf8_mode_ff) begin
                  left_in = '0; r0 = mk(KIND_TEXT, {24'd0, c}); n0 = 1'b1;
               end else if (c[7:6] == 2'b10) begin
                  if (left_ff == 3'd0) begin
                     r0 = mk(KIND_TEXT, REPLACEMENT); n0 = 1'b1;
                  end else begin
                     accum_in = {accum_ff[24:0], c[5:0]};
                     left_in = left_ff - 3'd1;
                     if (left_ff == 3'd1) begin
                        r0 = mk(KIND_TEXT, {1'b0, accum_in}); n0 = 1'b1;
                     end
                  end
               end else begin
                  left_in = '0;
                  if (left_ff != 3'd0) begin
                     r0 = mk(KIND_TEXT, REPLACEMENT); n0 = 1'b1;
                  end
                  priority if (c < 8'h80) begin
                     r1 = mk(KIND_TEXT, {24'd0, c}); n1 = 1'b1;
                  end else if (c < 8'he0) begin
                     accum_in = {26'd0, c[4:0]}; left_in = 3'd1;
                  end else if (c < 8'hf0) begin
                     accum_in = {27'd0, c[3:0]}; left_in = 3'd2;
                  end else if (c < 8'hf8) begin
                     accum_in = {28'd0, c[2:0]}; left_in = 3'd3;
                  end else if (c < 8'hfc) begin
                     accum_in = {29'd0, c[1:0]}; left_in = 3'd4;
                  end else if (c < 8'hfe) begin
                     accum_in = {30'd0, c[0]}; left_in = 3'd5;
                  end else begin
                     r1 = mk(KIND_TEXT, REPLACEMENT); n1 = 1'b1;
                  end
               end
            end
         endcase
         // place results: first into output, second pending
         if (n0 && n1) begin
            out_v_in = 1'b1; out_in = r0;
            pend_in = 1'b1; pend_res_in = r1; pend_res_in.last = 1'b1;
         end else if (n0 || n1) begin
            out_v_in = 1'b1; out_in = n0 ? r0 : r1; out_in.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         utf8_mode_ff <= 1'b1; mode_ff <= MODE_GROUND; left_ff <= '0;
         accum_ff <= '0; first_ff <= 1'b1; inter_ff <= 1'b1; istore_ff <= '0;
         icount_ff <= '0; aidx_ff <= '0; avalid_ff <= '0; priv_ff <= 1'b0;
         ovf_ff <= 1'b0; excess_ff <= 1'b0; pend_ff <= 1'b0; emit_ff <= 1'b0;
         rd_wait_ff <= 1'b0; digit_pend_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         if (csr_wr_en) utf8_mode_ff <= csr_wr_data;
         mode_ff <= mode_in; left_ff <= left_in; accum_ff <= accum_in;
         first_ff <= first_in; inter_ff <= inter_in; istore_ff <= istore_in;
         icount_ff <= icount_in; aidx_ff <= aidx_in; avalid_ff <= avalid_in;
         priv_ff <= priv_in; ovf_ff <= ovf_in; excess_ff <= excess_in;
         pend_ff <= pend_in; emit_ff <= emit_in; rd_wait_ff <= rd_wait_in;
         digit_pend_ff <= digit_pend_in; out_v_ff <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_res_ff <= pend_res_in; eidx_ff <= eidx_in; cmd_ff <= cmd_in;
      digit_ff <= digit_in; daddr_ff <= daddr_in; out_ff <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_value = out_ff.value;
   assign rsp_csi_command = out_ff.csi_command;
   assign rsp_csi_intermediates = out_ff.csi_intermediates;
   assign rsp_csi_intermed_count = out_ff.csi_intermed_count;
   assign rsp_csi_private = out_ff.csi_private;
   assign rsp_csi_overflow = out_ff.csi_overflow;
   assign rsp_last = out_ff.last;
endmodule

/* sv/tep_checker.sv */
module tep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_csi_command,
   input logic        rsp_csi_private,
   input logic        rsp_last
);
   import tep_pkg::*;

   // held result stays valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("rsp dropped");
   // stalled input transaction stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid) else $error("req dropped under stall");
   // non-csi results carry no command
   a_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_CSI |-> rsp_csi_command == 8'd0)
      else $error("command on non-csi");
   // private csi gives a single result
   a_priv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_csi_private |-> rsp_last && rsp_kind == KIND_CSI)
      else $error("private not single");
   // no input taken while a stalled result waits
   a_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall) else $error("input taken under stall");
endmodule

bind terminal_escape_utf8_parser tep_checker u_tep_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
   .rsp_csi_command(rsp_csi_command), .rsp_csi_private(rsp_csi_private),
   .rsp_last(rsp_last)
);

/* test/terminal_escape_utf8_parser_checker.sv */
`timescale 1ns / 1ps
module terminal_escape_utf8_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic signed [31:0] rsp_value,
   input  logic [7:0]  rsp_csi_command,
   input  logic [15:0] rsp_csi_intermediates,
   input  logic [1:0]  rsp_csi_intermed_count,
   input  logic        rsp_csi_private,
   input  logic        rsp_csi_overflow,
   input  logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          fail_count,
   output int          pending_count
);
   import tep_pkg::*;

   localparam int NumArgs = 16;
   localparam int NumIntermed = 2;

   // predictor state
   logic        utf8_on;
   mode_type    mode;
   logic [2:0]  bytes_left;
   logic [30:0] cp_accum;
   logic        first_byte;
   logic        in_intermed;
   logic [15:0] intermed;
   logic [1:0]  intermed_n;
   logic [3:0]  arg_idx;
   int          args [NumArgs];
   logic        priv;
   logic        ovf;
   logic        excess;

   result_type expected_results[$];

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic push_result(input logic [1:0] k, input logic [31:0] v, input logic [7:0] cmd,
                              input logic [15:0] im, input logic [1:0] cnt,
                              input logic p, input logic o);
      result_type r;
      r = '{kind: k, value: v, csi_command: cmd, csi_intermediates: im,
            csi_intermed_count: cnt, csi_private: p, csi_overflow: o, last: 1'b0};
      expected_results.push_back(r);
   endtask

   // result with all csi fields zero
   task automatic push_plain(input logic [1:0] k, input logic [31:0] v);
      push_result(k, v, 8'd0, 16'd0, 2'd0, 1'b0, 1'b0);
   endtask

   task automatic enter_csi();
      mode = MODE_CSI;
      first_byte = 1'b1;
      in_intermed = 1'b1;
      intermed = '0;
      intermed_n = '0;
      arg_idx = '0;
      for (int i = 0; i < NumArgs; i++) args[i] = -1;
      priv = 1'b0;
      ovf = 1'b0;
      excess = 1'b0;
   endtask

   task automatic csi_body(input logic [7:0] c);
      int v;
      if (first_byte) begin
         first_byte = 1'b0;
         if (c >= 8'h3c && c <= 8'h3e) begin
            priv = 1'b1;
            return;
         end
      end
      if (priv) return;
      if (in_intermed) begin
         if (c[7:4] == 4'h2 || c == BYTE_QUEST) begin
            if (intermed_n < NumIntermed) begin
               intermed = {intermed[7:0], c};
               intermed_n++;
            end else begin
               ovf = 1'b1;
            end
            return;
         end
         in_intermed = 1'b0;
      end
      if (c >= 8'h30 && c <= 8'h39) begin
         if (!excess) begin
            v = args[arg_idx];
            if (v < 0) v = 0;
            v = v * 10 + int'(c - 8'h30);
            if (v > 65535) begin
               v = 65535;
               ovf = 1'b1;
            end
            args[arg_idx] = v;
         end
      end else if (c == BYTE_SEMI) begin
         if (arg_idx != 4'(NumArgs - 1)) arg_idx++;
         else begin
            excess = 1'b1;
            ovf = 1'b1;
         end
      end
   endtask

   task automatic ground_body(input logic [7:0] c);
      if (c < 8'h20 || (!utf8_on && c >= 8'h80 && c < 8'ha0)) begin
         bytes_left = '0;
         if (c == BYTE_ESC) mode = MODE_ESCAPE;
         else if (c == BYTE_CSI) enter_csi();
         else push_plain(KIND_CTRL, 32'(c));
         return;
      end
      if (!utf8_on) begin
         bytes_left = '0;
         push_plain(KIND_TEXT, 32'(c));
         return;
      end
      if (c[7:6] == 2'b10) begin
         if (bytes_left == 0) push_plain(KIND_TEXT, REPLACEMENT);
         else begin
            cp_accum = {cp_accum[24:0], c[5:0]};
            bytes_left--;
            if (bytes_left == 0) push_plain(KIND_TEXT, 32'(cp_accum));
         end
         return;
      end
      if (bytes_left != 0) push_plain(KIND_TEXT, REPLACEMENT);
      bytes_left = '0;
      if (c < 8'h80) push_plain(KIND_TEXT, 32'(c));
      else if (c < 8'he0) begin cp_accum = 31'(c & 8'h1f); bytes_left = 3'd1; end
      else if (c < 8'hf0) begin cp_accum = 31'(c & 8'h0f); bytes_left = 3'd2; end
      else if (c < 8'hf8) begin cp_accum = 31'(c & 8'h07); bytes_left = 3'd3; end
      else if (c < 8'hfc) begin cp_accum = 31'(c & 8'h03); bytes_left = 3'd4; end
      else if (c < 8'hfe) begin cp_accum = 31'(c & 8'h01); bytes_left = 3'd5; end
      else push_plain(KIND_TEXT, REPLACEMENT);
   endtask

   // one input byte: expected results, last flag on the final one
   task automatic predict_byte(input logic [7:0] c);
      int before_n;
      before_n = expected_results.size();
      if (mode == MODE_ESCAPE) begin
         if (c == BYTE_LBRACKET) enter_csi();
         else begin
            push_plain(KIND_ESC, 32'(c));
            mode = MODE_GROUND;
         end
      end else if (mode == MODE_CSI) begin
         if (c >= 8'h40 && c <= 8'h7f) begin
            if (priv) push_result(KIND_CSI, 32'hffff_ffff, c, 16'd0, 2'd0, 1'b1, 1'b0);
            else for (int k = 0; k <= int'(arg_idx); k++)
               push_result(KIND_CSI, 32'(args[k]), c, intermed, intermed_n, 1'b0, ovf);
            mode = MODE_GROUND;
         end else begin
            csi_body(c);
         end
      end else begin
         ground_body(c);
      end
      if (expected_results.size() > before_n)
         expected_results[expected_results.size() - 1].last = 1'b1;
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         utf8_on = 1'b1;
         bytes_left = '0;
         cp_accum = '0;
         enter_csi();
         mode = MODE_GROUND;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) utf8_on = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction kind %0d value %0d",
                                         rsp_kind, rsp_value));
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d want %0d", rsp_kind, want.kind));
               if (rsp_value !== want.value)
                  report_mismatch($sformatf("value %0h want %0h", rsp_value, want.value));
               if (rsp_csi_command !== want.csi_command)
                  report_mismatch($sformatf("command %0h want %0h",
                                            rsp_csi_command, want.csi_command));
               if (rsp_csi_intermediates !== want.csi_intermediates)
                  report_mismatch($sformatf("intermediates %0h want %0h",
                                            rsp_csi_intermediates, want.csi_intermediates));
               if (rsp_csi_intermed_count !== want.csi_intermed_count)
                  report_mismatch($sformatf("intermediate count %0d want %0d",
                                            rsp_csi_intermed_count, want.csi_intermed_count));
               if (rsp_csi_private !== want.csi_private)
                  report_mismatch($sformatf("private %0b want %0b",
                                            rsp_csi_private, want.csi_private));
               if (rsp_csi_overflow !== want.csi_overflow)
                  report_mismatch($sformatf("overflow %0b want %0b",
                                            rsp_csi_overflow, want.csi_overflow));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b want %0b", rsp_last, want.last));
            end
         end
         if (req_valid && !req_stall) predict_byte(req_in_byte);
      end
      pending_count = expected_results.size();
   end
endmodule

/* test/terminal_escape_utf8_parser_tb.sv */
`timescale 1ns / 1ps
module terminal_escape_utf8_parser_tb;
   import tep_pkg::*;

   localparam int CycleLimit = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic signed [31:0] rsp_value;
   logic [7:0]  rsp_csi_command;
   logic [15:0] rsp_csi_intermediates;
   logic [1:0]  rsp_csi_intermed_count;
   logic        rsp_csi_private;
   logic        rsp_csi_overflow;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;

   always #5 clock = ~clock;

   terminal_escape_utf8_parser dut (.*);

   terminal_escape_utf8_parser_checker checker_inst (.*);

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver stalls: random, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // offer one byte; valid stays up until the next byte or an idle cycle
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_seq(input logic [7:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(9));
   endfunction

   // one random chunk of terminal traffic, not always well-formed
   task automatic send_random_chunk();
      logic [7:0] s[$];
      int n;
      case ($urandom_range(7))
         0: s = {8'($urandom_range(8'h20, 8'h7e))};
         1: s = {8'hc0 | 8'($urandom_range(31)), 8'h80 | 8'($urandom_range(63))};
         2: s = {8'he0 | 8'($urandom_range(15)), 8'h80 | 8'($urandom_range(63)),
                 8'h80 | 8'($urandom_range(63))};
         3: begin
            s = {8'hf0 | 8'($urandom_range(7))};
            repeat (3) s.push_back(8'h80 | 8'($urandom_range(63)));
         end
         4: begin
            s = {($urandom_range(1) ? BYTE_CSI : BYTE_ESC)};
            if (s[0] == BYTE_ESC) s.push_back(BYTE_LBRACKET);
            if ($urandom_range(3) == 0) s.push_back(8'h3c + 8'($urandom_range(2)));
            repeat ($urandom_range(2)) s.push_back(8'h20 + 8'($urandom_range(15)));
            n = $urandom_range(4);
            for (int a = 0; a <= n; a++) begin
               repeat ($urandom_range(3)) s.push_back(rand_digit());
               if (a < n) s.push_back(BYTE_SEMI);
            end
            s.push_back(8'($urandom_range(8'h40, 8'h7f)));
         end
         5: s = {BYTE_ESC, 8'($urandom_range(255))};
         default: s = {8'($urandom_range(255))};
      endcase
      send_seq(s);
   endtask

   initial begin
      logic [7:0] s[$];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: text extremes, utf-8 forms and faults, escapes, csi cases
      send_seq({8'h00, 8'h41, 8'h7f, 8'he2, 8'h82, 8'hac, 8'hfd, 8'hbf, 8'hbf, 8'hbf,
                8'hbf, 8'hbf, 8'hc3, 8'h0a, 8'hc3, 8'h41, 8'h80, 8'hfe, 8'hff});
      send_seq({BYTE_ESC, 8'h37, BYTE_ESC, BYTE_LBRACKET, 8'h20, 8'h21, 8'h22,
                8'h31, BYTE_SEMI, BYTE_SEMI, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
                8'h0a, 8'h6d});
      send_seq({BYTE_CSI, 8'h3f, 8'h32, 8'h35, 8'h68, BYTE_CSI, 8'h3e, 8'h31, 8'h63,
                BYTE_CSI, 8'h40});
      s = {BYTE_CSI};
      repeat (17) s.push_back(BYTE_SEMI);
      s.push_back(8'h48);
      send_seq(s);
      drain();

      // 8-bit mode: c1 controls and csi
      write_mode(1'b0);
      send_seq({8'h80, 8'h9f, 8'ha0, 8'hff, BYTE_CSI, 8'h35, 8'h41, 8'hc3});
      drain();
      write_mode(1'b1);
      send_seq({8'he2, 8'h82});
      drain();
      write_mode(1'b0);
      send_seq({8'h41});
      drain();
      write_mode(1'b1);

      // long receiver hold-off while bytes keep coming
      hold_cycles = 60;
      repeat (10) send_byte(8'($urandom_range(8'h20, 8'h7e)));
      drain();

      // random phases with rotating idle patterns
      send_idle_pct = 8;
      recv_idle_pct = 50;
      repeat (4) send_random_chunk();
      drain();
      write_mode(1'b0);
      send_idle_pct = 50;
      recv_idle_pct = 8;
      repeat (3) send_random_chunk();
      drain();
      write_mode(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (4) send_random_chunk();
      drain();

      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

/* files.f */
sv/tep_pkg.sv
sv/tep_arg_ram.sv
sv/terminal_escape_utf8_parser.sv
sv/tep_checker.sv
test/terminal_escape_utf8_parser_checker.sv
test/terminal_escape_utf8_parser_tb.sv
